/* sv/mbt_pkg.sv */
// Shared constants for the metronome beat timer.
`default_nettype none
package mbt_pkg;

   // Default width of the wrapping millisecond time base
   localparam int TIME_BITS_DEF = 32;

   // Port widths
   localparam int NOW_W   = 32;
   localparam int TEMPO_W = 10;
   localparam int MEAS_W  = 3;
   localparam int DUTY_W  = 13;
   localparam int RSP_W   = 16;
   localparam int CSR_A_W = 1;

   // Register indexes on the configuration channel
   localparam logic [CSR_A_W-1:0] REG_TEMPO   = 1'd0;
   localparam logic [CSR_A_W-1:0] REG_MEASURE = 1'd1;

   // Reset values of the registers
   localparam logic [TEMPO_W-1:0] TEMPO_RST   = 10'd200;
   localparam logic [MEAS_W-1:0]  MEASURE_RST = 3'd2;

   // Beat period numerator and the serial divider it sets
   localparam int                 DIVIDEND_W    = 16;
   localparam logic [DIVIDEND_W-1:0] MS_PER_MINUTE = 16'd60000;

   // Beep length and tone compare values
   localparam logic [5:0]        BEEP_MS     = 6'd50;
   localparam logic [DUTY_W-1:0] DUTY_NORMAL = 13'd2000;
   localparam logic [DUTY_W-1:0] DUTY_ACCENT = 13'd8000;

endpackage : mbt_pkg
`default_nettype wire

/* sv/metronome_beat_timer.sv */
// Metronome beat timer: serial tempo divider and one shared adder/comparator under a sequencer.
// Each taken request runs 16-bit restoring division for 60000/tempo, then compare/add steps
// on the shared TIME_BITS adder (compare next beat, add period and beep length only when a
// beat starts, compare beep end), then loads the result once the result side is free.
// A new request is not taken until the last result is loaded; req_tready is high only while
// the sequencer idles.
// Synchronous active-high reset clears all beat state and loads tempo 200, measure 2.
`default_nettype none
module metronome_beat_timer
   import mbt_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // Request channel
   input  wire logic                req_tvalid,
   output      logic                req_tready,
   input  wire logic [NOW_W-1:0]    req_tdata,   // [31:0] now_ms
   // Result channel
   output      logic                rsp_tvalid,
   input  wire logic                rsp_tready,
   output      logic [RSP_W-1:0]    rsp_tdata,   // [0] beep_active, [1] accent_beat,
                                                 // [14:2] tone_duty, [15] beat_started
   // Configuration channel
   input  wire logic                csr_valid,
   output      logic                csr_ready,
   input  wire logic [CSR_A_W-1:0]  csr_addr,
   input  wire logic [TEMPO_W-1:0]  csr_data
);

   // Sequencer codes
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_CMPN = 3'd2;
   localparam logic [2:0] S_ADDP = 3'd3;
   localparam logic [2:0] S_ADDE = 3'd4;
   localparam logic [2:0] S_CMPE = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   localparam int CNT_W = $clog2(DIVIDEND_W);

   // Registers
   logic [2:0]            state_ff, state_in;
   logic [TEMPO_W-1:0]    tempo_ff, tempo_in;
   logic [MEAS_W-1:0]     meas_ff, meas_in;
   logic [TIME_BITS-1:0]  now_ff, now_in;
   logic [TIME_BITS-1:0]  next_beat_ff, next_beat_in;
   logic [TIME_BITS-1:0]  beep_end_ff, beep_end_in;
   logic [MEAS_W-1:0]     beat_cnt_ff, beat_cnt_in;
   logic                  beeping_ff, beeping_in;
   logic                  chosen_ff, chosen_in;
   logic                  accent_ff, accent_in;
   logic [DUTY_W-1:0]     duty_ff, duty_in;
   logic                  started_ff, started_in;
   logic [TEMPO_W-1:0]    rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]      rsp_data_ff, rsp_data_in;

   // Shared adder/comparator
   logic [TIME_BITS-1:0]  alu_a, alu_b;
   logic                  alu_sub;
   logic [TIME_BITS:0]    alu_sum;
   logic                  alu_carry;

   logic [TEMPO_W-1:0]    tempo_eff;
   logic [TEMPO_W:0]      rem_shift;
   logic [MEAS_W-1:0]     cnt_clean;
   logic                  req_fire;
   logic                  rsp_free;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // Treat zero tempo as one beat per minute
   assign tempo_eff = (tempo_ff == '0) ? TEMPO_W'(1) : tempo_ff;

   // Next partial remainder of the restoring divider
   assign rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};

   // Clear a count that has run past the measure size
   assign cnt_clean = (beat_cnt_ff > meas_ff) ? '0 : beat_cnt_ff;

   // Select operands for the shared unit
   always_comb begin
      alu_a   = now_ff;
      alu_b   = now_ff;
      alu_sub = 1'b1;
      case (state_ff)
         S_DIV: begin
            alu_a = TIME_BITS'(rem_shift);
            alu_b = TIME_BITS'(tempo_eff);
         end
         S_CMPN: begin
            alu_a = next_beat_ff;
         end
         S_ADDP: begin
            alu_b   = TIME_BITS'(quo_ff);
            alu_sub = 1'b0;
         end
         S_ADDE: begin
            alu_b   = TIME_BITS'(BEEP_MS);
            alu_sub = 1'b0;
         end
         S_CMPE: begin
            alu_a = beep_end_ff;
         end
         default: begin
            alu_sub = 1'b1;
         end
      endcase
   end

   assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                      + (TIME_BITS + 1)'(alu_sub);
   assign alu_carry = alu_sum[TIME_BITS];

   // Sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      tempo_in     = tempo_ff;
      meas_in      = meas_ff;
      now_in       = now_ff;
      next_beat_in = next_beat_ff;
      beep_end_in  = beep_end_ff;
      beat_cnt_in  = beat_cnt_ff;
      beeping_in   = beeping_ff;
      chosen_in    = chosen_ff;
      accent_in    = accent_ff;
      duty_in      = duty_ff;
      started_in   = started_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // Take register writes
      if (csr_valid) begin
         case (csr_addr)
            REG_TEMPO:   tempo_in = csr_data;
            REG_MEASURE: meas_in  = csr_data[MEAS_W-1:0];
            default:     tempo_in = tempo_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               now_in      = TIME_BITS'(req_tdata);
               beat_cnt_in = cnt_clean;
               // Choose the next beat's settings while the beep is off
               if (!beeping_ff && !chosen_ff) begin
                  if (cnt_clean != meas_ff) begin
                     duty_in   = DUTY_NORMAL;
                     accent_in = 1'b0;
                  end else begin
                     duty_in     = DUTY_ACCENT;
                     accent_in   = 1'b1;
                     beat_cnt_in = '0;
                  end
                  chosen_in = 1'b1;
               end
               rem_in   = '0;
               quo_in   = MS_PER_MINUTE;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // One quotient bit per cycle
            if (alu_carry) begin
               rem_in = alu_sum[TEMPO_W-1:0];
            end else begin
               rem_in = rem_shift[TEMPO_W-1:0];
            end
            quo_in = {quo_ff[DIVIDEND_W-2:0], alu_carry};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
               state_in = S_CMPN;
            end
         end
         S_CMPN: begin
            // Beat due when the stored time is below now
            started_in = !alu_carry;
            state_in   = alu_carry ? S_CMPE : S_ADDP;
         end
         S_ADDP: begin
            next_beat_in = alu_sum[TIME_BITS-1:0];
            state_in     = S_ADDE;
         end
         S_ADDE: begin
            beep_end_in = alu_sum[TIME_BITS-1:0];
            beeping_in  = 1'b1;
            beat_cnt_in = beat_cnt_ff + MEAS_W'(1);
            chosen_in   = 1'b0;
            state_in    = S_CMPE;
         end
         S_CMPE: begin
            // Stop the beep once now passes its end
            if (!alu_carry) begin
               beeping_in = 1'b0;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            // Hold until the result register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {started_ff, duty_ff, accent_ff, beeping_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tempo_ff     <= TEMPO_RST;
         meas_ff      <= MEASURE_RST;
         next_beat_ff <= '0;
         beep_end_ff  <= '0;
         beat_cnt_ff  <= '0;
         beeping_ff   <= 1'b0;
         chosen_ff    <= 1'b0;
         accent_ff    <= 1'b0;
         duty_ff      <= '0;
         started_ff   <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tempo_ff     <= tempo_in;
         meas_ff      <= meas_in;
         next_beat_ff <= next_beat_in;
         beep_end_ff  <= beep_end_in;
         beat_cnt_ff  <= beat_cnt_in;
         beeping_ff   <= beeping_in;
         chosen_ff    <= chosen_in;
         accent_ff    <= accent_in;
         duty_ff      <= duty_in;
         started_ff   <= started_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule : metronome_beat_timer
`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the metronome beat timer: stream driver, monitor, beat predictor.
`timescale 1ns / 100ps
module tb_top;
   import mbt_pkg::*;

   // One beat-timer result as it sits in rsp_tdata, lowest field last
   typedef struct packed {
      logic              started;
      logic [DUTY_W-1:0] duty;
      logic              accent;
      logic              beep;
   } beat_result_t;

   localparam int NUM_PHASES = 10;
   localparam int PHASE_ITEMS = 70;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 30;
   localparam int MAX_REPORTS = 10;

   // Tempo and measure for each random phase
   localparam int unsigned PH_TEMPO [NUM_PHASES] =
      '{1000, 1, 200, 1023, 0, 60, 513, 300, 999, 2};
   localparam int unsigned PH_MEASURE [NUM_PHASES] =
      '{4, 2, 7, 0, 3, 1, 5, 4, 6, 2};

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [NOW_W-1:0]    req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_W-1:0]    rsp_tdata;    // [0] beep_active, [1] accent_beat,
                                      // [14:2] tone_duty, [15] beat_started
   logic                csr_valid;
   logic                csr_ready;
   logic [CSR_A_W-1:0]  csr_addr;
   logic [TEMPO_W-1:0]  csr_data;

   // Pending times, expected beat results
   logic [NOW_W-1:0]    now_q [$];
   beat_result_t        expected_beats [$];

   // Predictor copy of configuration and beat state
   logic [TEMPO_W-1:0]  cfg_tempo;
   logic [MEAS_W-1:0]   cfg_measure;
   logic [31:0]         m_next_beat;
   logic [31:0]         m_beep_end;
   logic [2:0]          m_count;
   logic                m_beeping;
   logic                m_chosen;
   logic                m_accent;
   logic [13:0]         m_duty;

   int unsigned         send_idle_pct;
   int unsigned         rsp_stall_pct;
   logic                req_taken;
   logic                hold_kick;
   int unsigned         hold_left;
   int unsigned         fail_count;
   logic [31:0]         time_cursor;
   beat_result_t        got_beat;
   beat_result_t        want_beat;

   metronome_beat_timer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_data   (csr_data)
   );

   // Free-running clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Advance the beat state by one millisecond sample and form its result
   function automatic beat_result_t advance_metronome(input logic [NOW_W-1:0] now);
      beat_result_t res;
      logic [15:0]  divisor;
      logic [31:0]  period;
      logic         began;
      divisor = (cfg_tempo == '0) ? 16'd1 : 16'(cfg_tempo);
      period = 32'(MS_PER_MINUTE / divisor);
      began = 1'b0;
      // Clear a count left above the measure size
      if (m_count > cfg_measure) m_count = 3'd0;
      // Pick the next beat's settings while quiet
      if (!m_beeping && !m_chosen) begin
         if (m_count != cfg_measure) begin
            m_duty = 14'(DUTY_NORMAL);
            m_accent = 1'b0;
         end else begin
            m_duty = 14'(DUTY_ACCENT);
            m_accent = 1'b1;
            m_count = 3'd0;
         end
         m_chosen = 1'b1;
      end
      // Start a beep when the beat time has passed
      if (m_next_beat < now) begin
         m_next_beat = now + period;
         m_beep_end = now + 32'(BEEP_MS);
         m_beeping = 1'b1;
         m_count = m_count + 3'd1;
         m_chosen = 1'b0;
         began = 1'b1;
      end
      if (now > m_beep_end) m_beeping = 1'b0;
      res.beep = m_beeping;
      res.accent = m_accent;
      res.duty = m_duty[DUTY_W-1:0];
      res.started = began;
      return res;
   endfunction

   // Next random sample time: mostly forward steps, some jumps, wraps and noise
   function automatic logic [31:0] next_time();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 60) time_cursor = time_cursor + $urandom_range(1, 16);
      else if (pick < 80) time_cursor = time_cursor + $urandom_range(50, 700);
      else if (pick < 88) time_cursor = time_cursor - $urandom_range(0, 100);
      else if (pick < 95) time_cursor = $urandom();
      else time_cursor = 32'hFFFF_FFFF - $urandom_range(0, 300);
      return time_cursor;
   endfunction

   // Take requests into the predictor as they are accepted
   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready)
         expected_beats.push_back(advance_metronome(req_tdata));
   end

   // Drive requests from the pending queue with random gaps
   always @(negedge clock) begin
      if (!req_tvalid || req_taken) begin
         if (now_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata <= now_q.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Count down a long result-side hold
   always @(posedge clock) begin
      if (hold_kick) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   // Stall the result side at random or while held
   always @(negedge clock) begin
      rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
   end

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_beat = beat_result_t'(rsp_tdata);
         if (expected_beats.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("%0t: unexpected result beep=%0b accent=%0b duty=%0d started=%0b",
                        $realtime, got_beat.beep, got_beat.accent, got_beat.duty,
                        got_beat.started);
         end else begin
            want_beat = expected_beats.pop_front();
            if (got_beat.beep !== want_beat.beep || got_beat.accent !== want_beat.accent ||
                got_beat.duty !== want_beat.duty || got_beat.started !== want_beat.started) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: mismatch exp beep=%0b accent=%0b duty=%0d started=%0b, %s%0b %s%0b %s%0d %s%0b",
                           $realtime, want_beat.beep, want_beat.accent, want_beat.duty,
                           want_beat.started, "got beep=", got_beat.beep, "accent=",
                           got_beat.accent, "duty=", got_beat.duty, "started=",
                           got_beat.started);
            end
         end
      end
   end

   // Write one register, then update the predictor's copy
   task automatic write_csr(input logic [CSR_A_W-1:0] addr, input logic [TEMPO_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_addr <= addr;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (addr == REG_TEMPO) cfg_tempo = data;
      else cfg_measure = data[MEAS_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait until every request is out and every result is back, then let the block go idle
   task automatic settle();
      while (now_q.size() != 0 || req_tvalid || expected_beats.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Bound the run
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Reset, directed requests, then random phases
   initial begin
      int unsigned mode;
      logic [TEMPO_W-1:0] meas_word;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_addr = '0;
      csr_data = '0;
      req_taken = 1'b0;
      hold_kick = 1'b0;
      hold_left = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      fail_count = 0;
      cfg_tempo = TEMPO_RST;
      cfg_measure = MEASURE_RST;
      m_next_beat = '0;
      m_beep_end = '0;
      m_count = '0;
      m_beeping = 1'b0;
      m_chosen = 1'b0;
      m_accent = 1'b0;
      m_duty = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: strict beat and beep-end edges, time extremes and wrap
      now_q = '{32'd0, 32'd1, 32'd51, 32'd52, 32'd301, 32'd302, 32'hFFFF_FFFF, 32'd0,
                32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555};
      settle();

      // Zero tempo and a measure of zero: 60 s period, every beat accented
      write_csr(REG_TEMPO, 10'd0);
      write_csr(REG_MEASURE, 10'h3F8);
      @(posedge clock);
      now_q = '{32'd100, 32'd60101, 32'd60102, 32'd120103};
      settle();

      // Fastest tempo, largest measure: back-to-back beats during a beep wrap the count
      write_csr(REG_TEMPO, 10'd1023);
      write_csr(REG_MEASURE, 10'd7);
      @(posedge clock);
      for (int k = 0; k < 8; k++) now_q.push_back(32'd200000 + 32'(60 * k));
      settle();

      time_cursor = 32'd300000;
      for (int p = 0; p < NUM_PHASES; p++) begin
         meas_word = {7'($urandom()), 3'(PH_MEASURE[p])};
         write_csr(REG_TEMPO, (p == 7) ? 10'($urandom_range(1023)) : 10'(PH_TEMPO[p]));
         write_csr(REG_MEASURE, meas_word);
         @(posedge clock);
         mode = p % 4;
         send_idle_pct = (mode == 1) ? 75 : (mode == 3) ? 27 : 0;
         rsp_stall_pct = (mode == 2) ? 75 : (mode == 3) ? 27 : 0;
         // Hold the result side long enough to back the block up
         if (p == 0) begin
            @(negedge clock);
            hold_kick = 1'b1;
            @(negedge clock);
            hold_kick = 1'b0;
         end
         for (int i = 0; i < PHASE_ITEMS; i++) now_q.push_back(next_time());
         settle();
      end

      if (fail_count == 0 && expected_beats.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
